// ===== design/msd_pkg.sv =====
// ---------------------------------------------------------------------------
// msd_pkg
// Shared constants and types for the mean squared displacement block.
// ---------------------------------------------------------------------------
package msd_pkg;

    localparam int MAX_FRAMES    = 1024;
    localparam int MAX_MOLECULES = 16;
    localparam int MAX_LAG       = 64;
    localparam int COORD_W       = 24;

    localparam int FRAME_W = $clog2(MAX_FRAMES);
    localparam int FCNT_W  = FRAME_W + 1;
    localparam int SLOT_W  = $clog2(MAX_MOLECULES);
    localparam int ADDR_W  = FRAME_W + SLOT_W;
    localparam int DEPTH   = MAX_FRAMES * MAX_MOLECULES;

    localparam int MC_W   = 5;
    localparam int LAG_W  = 7;
    localparam int SUM_W  = 64;
    localparam int MSD_W  = 48;
    localparam int DIFF_W = COORD_W + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int DIV_W  = FRAME_W + MC_W;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_ADDR_W-1:0] REG_MOLECULE_COUNT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LAG           = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THREE_DIMENSIONAL = 2'd2;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== design/msd_ram.sv =====
// ---------------------------------------------------------------------------
// msd_ram
// Generic single write, single read RAM with registered read data.
// ---------------------------------------------------------------------------
module msd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/msd_div.sv =====
// ---------------------------------------------------------------------------
// msd_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module msd_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  msd_pkg::div_ctrl_t                ctrl,
    input  logic [msd_pkg::SUM_W-1:0]         dividend,
    input  logic [msd_pkg::DIV_W-1:0]         divisor,
    output msd_pkg::div_stat_t                stat,
    output logic [msd_pkg::SUM_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(msd_pkg::SUM_W);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [msd_pkg::SUM_W-1:0]     quot_reg, quot_next;
    logic [msd_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [msd_pkg::DIV_W:0]       shifted;
    logic                          ge;

    always_comb begin
        shifted   = {rem_reg, quot_reg[msd_pkg::SUM_W-1]};
        ge        = shifted >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? msd_pkg::DIV_W'(shifted - {1'b0, divisor})
                           : shifted[msd_pkg::DIV_W-1:0];
            quot_next = {quot_reg[msd_pkg::SUM_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(msd_pkg::SUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

// ===== design/mean_squared_displacement_by_lag.sv =====
// ---------------------------------------------------------------------------
// mean_squared_displacement_by_lag
// Stores a trajectory of positions and emits the mean squared displacement
// for each lag once the trajectory ends.
// ---------------------------------------------------------------------------
//  channel   direction  payload
//  s_*       in         pos_x, pos_y, pos_z in tdata, end_of_trajectory in tlast
//  m_*       out        lag, msd, valid_res, overflow in tdata, last in tlast
//  cfg_*     in         register writes, no read-back
//
//  loading takes one transfer per cycle, s_tready is high while idle
//  per valid lag: (frames - lag) * molecules terms, each read from the store and
//  passed axis by axis through one shared squarer and accumulator, then the divider
//  an invalid lag goes straight to a zero result; each result waits in m_tdata for m_tready
//  reset is synchronous active low, no store clearing pass is needed
// ---------------------------------------------------------------------------
module mean_squared_displacement_by_lag (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [71:0]                        s_tdata,   // pos_x, pos_y, pos_z
    input  logic                               s_tlast,   // end_of_trajectory
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,   // lag, msd, valid_res, overflow
    output logic                               m_tlast,   // last
    input  logic                               cfg_we,
    input  logic [msd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [msd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int CW = msd_pkg::COORD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_LAG_INIT, S_RD_P, S_RD_Q, S_LATCH_Q, S_DIFF, S_MUL, S_ACC,
        S_NEXT, S_DIV_START, S_DIV_WAIT, S_OUT
    } state_t;

    state_t                          state_reg;
    logic [msd_pkg::MC_W-1:0]        mc_cfg_reg;
    logic [msd_pkg::LAG_W-1:0]       lag_cfg_reg;
    logic                            dim3_reg;
    logic [msd_pkg::FCNT_W-1:0]      frame_count_reg;
    logic [msd_pkg::SLOT_W-1:0]      slot_reg;
    logic                            dropped_reg;
    logic [msd_pkg::LAG_W-1:0]       lag_reg;
    logic [msd_pkg::FRAME_W-1:0]     i_reg;
    logic [msd_pkg::SLOT_W-1:0]      m_reg;
    logic [1:0]                      axis_reg;
    logic [CW-1:0]                   p_reg [3];
    logic [CW-1:0]                   q_reg [3];
    logic [msd_pkg::DIFF_W-1:0]      mag_reg;
    logic [msd_pkg::SQ_W-1:0]        sq_reg;
    logic [msd_pkg::SUM_W-1:0]       sum_reg;
    logic [msd_pkg::DIV_W-1:0]       divisor_reg;
    logic                            out_valid_reg;
    logic [msd_pkg::LAG_W-1:0]       out_lag_reg;
    logic [msd_pkg::MSD_W-1:0]       out_msd_reg;
    logic                            out_ok_reg;
    logic                            out_ovf_reg;
    logic                            out_last_reg;

    // clamped configuration
    logic [msd_pkg::MC_W-1:0]        mc;
    logic [msd_pkg::LAG_W-1:0]       lags;
    always_comb begin
        if (mc_cfg_reg == '0) mc = msd_pkg::MC_W'(1);
        else if (mc_cfg_reg > msd_pkg::MC_W'(msd_pkg::MAX_MOLECULES))
            mc = msd_pkg::MC_W'(msd_pkg::MAX_MOLECULES);
        else mc = mc_cfg_reg;
        if (lag_cfg_reg == '0) lags = msd_pkg::LAG_W'(1);
        else if (lag_cfg_reg > msd_pkg::LAG_W'(msd_pkg::MAX_LAG))
            lags = msd_pkg::LAG_W'(msd_pkg::MAX_LAG);
        else lags = lag_cfg_reg;
    end

    logic in_xfer, out_xfer, store_full, slot_wrap;
    assign s_tready   = (state_reg == S_IDLE);
    assign in_xfer    = s_tvalid && s_tready;
    assign out_xfer   = out_valid_reg && m_tready;
    assign store_full = frame_count_reg >= msd_pkg::FCNT_W'(msd_pkg::MAX_FRAMES);
    assign slot_wrap  = ({1'b0, slot_reg} + 1'b1) >= mc;

    // store ports
    logic                              ram_we;
    logic [msd_pkg::ADDR_W-1:0]        waddr, raddr;
    logic [CW-1:0]                     rdata [3];
    logic [msd_pkg::FCNT_W-1:0]        q_frame;
    assign ram_we  = in_xfer && !store_full;
    assign waddr   = {frame_count_reg[msd_pkg::FRAME_W-1:0], slot_reg};
    assign q_frame = msd_pkg::FCNT_W'(i_reg) + msd_pkg::FCNT_W'(lag_reg);
    assign raddr   = (state_reg == S_RD_Q) ? {q_frame[msd_pkg::FRAME_W-1:0], m_reg}
                                           : {i_reg, m_reg};

    for (genvar a = 0; a < 3; a++) begin : g_store
        msd_ram #(.WIDTH(CW), .DEPTH(msd_pkg::DEPTH)) u_store (
            .aclk  (aclk),
            .we    (ram_we),
            .waddr (waddr),
            .wdata (s_tdata[a*CW +: CW]),
            .raddr (raddr),
            .rdata (rdata[a])
        );
    end

    // shared difference, square and saturating accumulate
    logic signed [msd_pkg::DIFF_W-1:0] diff;
    logic [msd_pkg::SUM_W:0]           acc;
    assign diff = msd_pkg::DIFF_W'($signed(q_reg[axis_reg]))
                - msd_pkg::DIFF_W'($signed(p_reg[axis_reg]));
    assign acc  = {1'b0, sum_reg} + (msd_pkg::SUM_W + 1)'(sq_reg);

    // divider
    msd_pkg::div_ctrl_t          div_ctrl;
    msd_pkg::div_stat_t          div_stat;
    logic [msd_pkg::SUM_W-1:0]   quotient;
    assign div_ctrl.start = (state_reg == S_DIV_START);

    msd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (sum_reg),
        .divisor  (divisor_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    logic lag_ok, last_axis, last_term;
    assign lag_ok    = msd_pkg::FCNT_W'(lag_reg) < frame_count_reg;
    assign last_axis = (axis_reg == 2'd2) || (axis_reg == 2'd1 && !dim3_reg);
    assign last_term = ({1'b0, m_reg} + 1'b1 >= mc)
                    && (q_frame + 1'b1 >= frame_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            mc_cfg_reg      <= msd_pkg::MC_W'(1);
            lag_cfg_reg     <= msd_pkg::LAG_W'(1);
            dim3_reg        <= 1'b1;
            frame_count_reg <= '0;
            slot_reg        <= '0;
            dropped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    msd_pkg::REG_MOLECULE_COUNT:    mc_cfg_reg  <= cfg_wdata[msd_pkg::MC_W-1:0];
                    msd_pkg::REG_MAX_LAG:           lag_cfg_reg <= cfg_wdata;
                    msd_pkg::REG_THREE_DIMENSIONAL: dim3_reg    <= cfg_wdata[0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (store_full) dropped_reg <= 1'b1;
                        if (slot_wrap) begin
                            slot_reg <= '0;
                            if (!store_full) frame_count_reg <= frame_count_reg + 1'b1;
                        end else begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                        if (s_tlast) begin
                            lag_reg   <= msd_pkg::LAG_W'(1);
                            state_reg <= S_LAG_INIT;
                        end
                    end
                end
                S_LAG_INIT: begin
                    i_reg       <= '0;
                    m_reg       <= '0;
                    sum_reg     <= '0;
                    divisor_reg <= msd_pkg::DIV_W'(frame_count_reg - msd_pkg::FCNT_W'(lag_reg))
                                 * msd_pkg::DIV_W'(mc);
                    if (lag_ok) begin
                        state_reg <= S_RD_P;
                    end else begin
                        out_msd_reg   <= '0;
                        out_ok_reg    <= 1'b0;
                        out_lag_reg   <= lag_reg;
                        out_ovf_reg   <= dropped_reg;
                        out_last_reg  <= (lag_reg == lags);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_RD_P: state_reg <= S_RD_Q;
                S_RD_Q: begin
                    p_reg     <= rdata;
                    state_reg <= S_LATCH_Q;
                end
                S_LATCH_Q: begin
                    q_reg     <= rdata;
                    axis_reg  <= 2'd0;
                    state_reg <= S_DIFF;
                end
                S_DIFF: begin
                    mag_reg   <= diff[msd_pkg::DIFF_W-1] ? msd_pkg::DIFF_W'(-diff)
                                                         : msd_pkg::DIFF_W'(diff);
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    sq_reg    <= mag_reg * mag_reg;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    sum_reg <= acc[msd_pkg::SUM_W] ? '1 : acc[msd_pkg::SUM_W-1:0];
                    if (last_axis) begin
                        state_reg <= S_NEXT;
                    end else begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= S_DIFF;
                    end
                end
                S_NEXT: begin
                    if (last_term) begin
                        state_reg <= S_DIV_START;
                    end else if ({1'b0, m_reg} + 1'b1 >= mc) begin
                        m_reg     <= '0;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_RD_P;
                    end else begin
                        m_reg     <= m_reg + 1'b1;
                        state_reg <= S_RD_P;
                    end
                end
                S_DIV_START: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_stat.done) begin
                        out_msd_reg   <= (|quotient[msd_pkg::SUM_W-1:msd_pkg::MSD_W])
                                         ? '1 : quotient[msd_pkg::MSD_W-1:0];
                        out_ok_reg    <= 1'b1;
                        out_lag_reg   <= lag_reg;
                        out_ovf_reg   <= dropped_reg;
                        out_last_reg  <= (lag_reg == lags);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_xfer) begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            frame_count_reg <= '0;
                            slot_reg        <= '0;
                            dropped_reg     <= 1'b0;
                            state_reg       <= S_IDLE;
                        end else begin
                            lag_reg   <= lag_reg + 1'b1;
                            state_reg <= S_LAG_INIT;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_ovf_reg, out_ok_reg, out_msd_reg, out_lag_reg};

    // loading and result delivery never overlap
    a_idle_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("result pending while loading");

    // frame counter never passes the store size
    a_frame_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_count_reg <= msd_pkg::FCNT_W'(msd_pkg::MAX_FRAMES))
        else $error("frame count beyond store");

    // an invalid lag carries a zero mean
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[55]) |-> (m_tdata[54:7] == '0))
        else $error("invalid lag with nonzero msd");

    // divider only runs while the sequencer waits on it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == S_DIV_WAIT))
        else $error("divider busy outside wait state");

endmodule
